// ----- sv/brb_pkg.sv -----
// Shared types and constants for the byte ring buffer.
package brb_pkg;

   localparam int OP_W         = 3;
   localparam int COUNT_W      = 10;
   localparam int SIZE_W       = 10;
   localparam int ST_W         = 2;
   localparam int DATA_BYTES   = 8;
   localparam int DATA_W       = 8 * DATA_BYTES;
   localparam int LANE_W       = 3;
   localparam int PASS_COUNT_W = 4;

   localparam logic [OP_W-1:0] OP_ENQUEUE    = 3'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE    = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK       = 3'd2;
   localparam logic [OP_W-1:0] OP_MOVE_REAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_MOVE_FRONT = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;
   localparam logic [OP_W-1:0] OP_QUERY      = 3'd6;

   localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
   localparam logic [ST_W-1:0] ST_REJECTED = 2'd1;
   localparam logic [ST_W-1:0] ST_OVERSIZE = 2'd2;

   // One access pass over the byte banks.
   typedef struct packed {
      logic                    clear;
      logic                    wr;
      logic                    rd;
      logic [LANE_W-1:0]       off;
      logic [PASS_COUNT_W-1:0] count;
   } pass_ctl_type;

   // Which byte lane a bank's read data belongs to.
   typedef struct packed {
      logic              en;
      logic [LANE_W-1:0] lane;
   } lane_sel_type;

endpackage

// ----- sv/brb_channels_if.sv -----
// Request and response channel interfaces of the byte ring buffer.
interface brb_req_if;
   logic                           valid;
   logic                           ready;
   logic [brb_pkg::OP_W-1:0]       operation;
   logic [brb_pkg::COUNT_W-1:0]    byte_count;
   logic [brb_pkg::DATA_W-1:0]     data_bytes;

   modport source (output valid, operation, byte_count, data_bytes, input ready);
   modport sink (input valid, operation, byte_count, data_bytes, output ready);
endinterface

interface brb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [brb_pkg::ST_W-1:0]    status;
   logic [brb_pkg::COUNT_W-1:0] done_count;
   logic [brb_pkg::DATA_W-1:0]  read_bytes;
   logic [brb_pkg::SIZE_W-1:0]  used_size;
   logic [brb_pkg::SIZE_W-1:0]  free_size;
   logic [brb_pkg::SIZE_W-1:0]  direct_enqueue_size;
   logic [brb_pkg::SIZE_W-1:0]  direct_dequeue_size;

   modport source (output valid, status, done_count, read_bytes, used_size, free_size,
                   direct_enqueue_size, direct_dequeue_size, input ready);
   modport sink (input valid, status, done_count, read_bytes, used_size, free_size,
                 direct_enqueue_size, direct_dequeue_size, output ready);
endinterface

// ----- sv/byte_ring_buffer.sv -----
// Top level of the byte ring buffer: sequencer, pointers, banks and response register.
//
//  Channel   Role   Handshake     Carries
//  req_chan  sink   valid/ready   operation, byte_count, data_bytes
//  rsp_chan  source valid/ready   status, done_count, read_bytes and the four sizes
//
//  A transaction runs from acceptance to the next acceptance through the steps of the
//  sequencer: check, a second bank pass when a data transfer runs past the end of the
//  store, pointer update and size report, after which the idle step takes the next
//  request.
//  Reset is synchronous and starts a clearing sweep over the ceil((CAPACITY+1)/BANKS) bank
//  rows, one bank row per cycle (128 rows by default); no request is taken until it ends.
//  The response register lets a new request in while the last result waits; the
//  report step holds until that register is free.
module byte_ring_buffer #(
   parameter int CAPACITY = 1023,
   parameter int LANES    = 8
) (
   input  logic            clock,
   input  logic            reset,
   brb_req_if.sink         req_chan,
   brb_rsp_if.source       rsp_chan
);

   localparam int SLOTS = CAPACITY + 1;
   localparam int PTR_W = $clog2(SLOTS);
   localparam int BL    = $clog2(LANES);
   localparam int BANKS = 1 << BL;
   localparam int ROWS  = (SLOTS + BANKS - 1) / BANKS;
   localparam int ROW_W = $clog2(ROWS);
   // Size arithmetic is wide enough for both the pointers and the 10-bit fields.
   localparam int SW    = ((PTR_W > brb_pkg::SIZE_W) ? PTR_W : brb_pkg::SIZE_W) + 1;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_WRAP   = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;
   localparam logic [2:0] S_REPORT = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [ROW_W-1:0]               clr_row_ff, clr_row_in;
   logic [PTR_W-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]               wr_ptr_ff, wr_ptr_in;
   logic                           adv_rd_ff, adv_rd_in;
   logic                           adv_wr_ff, adv_wr_in;
   logic                           wrap_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [brb_pkg::OP_W-1:0]       op_ff;
   logic [brb_pkg::COUNT_W-1:0]    count_ff;
   logic [brb_pkg::DATA_W-1:0]     data_ff;
   logic [brb_pkg::ST_W-1:0]       status_ff, status_in;
   logic [brb_pkg::COUNT_W-1:0]    done_ff, done_in;
   logic [brb_pkg::COUNT_W-1:0]    amt_ff, amt_in;
   logic [brb_pkg::LANE_W-1:0]     off_ff, off_in;

   logic [brb_pkg::ST_W-1:0]       rsp_status_ff;
   logic [brb_pkg::COUNT_W-1:0]    rsp_done_ff;
   logic [brb_pkg::DATA_W-1:0]     rsp_bytes_ff;
   logic [brb_pkg::SIZE_W-1:0]     rsp_used_ff, rsp_free_ff, rsp_denq_ff, rsp_ddeq_ff;

   logic                           req_fire;
   logic                           rsp_free_slot;
   logic                           is_enq, is_read, is_data;
   logic [PTR_W-1:0]               xfer_ptr;
   logic [SW-1:0]                  w, r, used_now, free_now, denq_now, ddeq_now;
   logic [SW-1:0]                  wr_sum, rd_sum;
   logic [PTR_W:0]                 xfer_end;
   logic [SW-1:0]                  wrap_gap;

   brb_pkg::pass_ctl_type          ctl;
   logic [PTR_W-1:0]               pass_base;
   brb_pkg::lane_sel_type          sel [BANKS];
   logic [7:0]                     bank_data [BANKS];
   logic [brb_pkg::DATA_W-1:0]     merged_bytes;

   assign req_fire      = req_chan.valid && req_chan.ready;
   assign rsp_free_slot = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   // Sizes as the pointers stand; the report step sees the committed pointers.
   always_comb begin
      w = SW'(wr_ptr_ff);
      r = SW'(rd_ptr_ff);
      if (w >= r) begin
         used_now = w - r;
         free_now = SW'(CAPACITY) - w + r;
         denq_now = (r == '0) ? SW'(CAPACITY) - w : SW'(CAPACITY) - w + SW'(1);
         ddeq_now = w - r;
      end else begin
         used_now = SW'(SLOTS) + w - r;
         free_now = r - w - SW'(1);
         denq_now = r - w - SW'(1);
         ddeq_now = SW'(SLOTS) - r;
      end
   end

   // Operation decode and the checks of the execute step.
   always_comb begin
      is_enq   = (op_ff == brb_pkg::OP_ENQUEUE);
      is_read  = (op_ff == brb_pkg::OP_DEQUEUE) || (op_ff == brb_pkg::OP_PEEK);
      is_data  = is_enq || is_read;
      xfer_ptr = is_enq ? wr_ptr_ff : rd_ptr_ff;
      xfer_end = {1'b0, xfer_ptr} + (PTR_W+1)'(count_ff[brb_pkg::PASS_COUNT_W-1:0]);
      wrap_gap = SW'(SLOTS) - SW'(xfer_ptr);

      if (is_data && (count_ff > brb_pkg::COUNT_W'(LANES))) begin
         status_in = brb_pkg::ST_OVERSIZE;
      end else if (is_enq && (SW'(count_ff) > free_now)) begin
         status_in = brb_pkg::ST_REJECTED;
      end else if (is_read && (SW'(count_ff) > used_now)) begin
         status_in = brb_pkg::ST_REJECTED;
      end else begin
         status_in = brb_pkg::ST_DONE;
      end

      case (op_ff)
         brb_pkg::OP_ENQUEUE, brb_pkg::OP_DEQUEUE, brb_pkg::OP_PEEK,
         brb_pkg::OP_MOVE_REAR, brb_pkg::OP_MOVE_FRONT: begin
            done_in = (status_in == brb_pkg::ST_DONE) ? count_ff : '0;
         end
         default: begin
            done_in = '0;
         end
      endcase

      adv_wr_in = (is_enq && (status_in == brb_pkg::ST_DONE))
                  || (op_ff == brb_pkg::OP_MOVE_REAR);
      adv_rd_in = ((op_ff == brb_pkg::OP_DEQUEUE) && (status_in == brb_pkg::ST_DONE))
                  || (op_ff == brb_pkg::OP_MOVE_FRONT);
      wrap_in   = is_data && (status_in == brb_pkg::ST_DONE)
                  && (xfer_end > (PTR_W+1)'(SLOTS));
      off_in    = brb_pkg::LANE_W'(wrap_gap);

      // Pointer moves take the count modulo the slot count; a few conditional
      // subtractions of shifted slot counts cover every 10-bit count.
      amt_in = count_ff;
      for (int k = brb_pkg::COUNT_W - 1; k >= 0; k--) begin
         if ((longint'(SLOTS) << k) < (longint'(1) << brb_pkg::COUNT_W)) begin
            if (amt_in >= brb_pkg::COUNT_W'(SLOTS << k)) begin
               amt_in = amt_in - brb_pkg::COUNT_W'(SLOTS << k);
            end
         end
      end
   end

   // Bank pass control. The first pass covers the bytes up to the end of the
   // store; the second one, when needed, the bytes that wrap to slot zero.
   always_comb begin
      ctl       = '0;
      pass_base = '0;
      case (state_ff)
         S_CLEAR: begin
            ctl.clear = 1'b1;
         end
         S_EXEC: begin
            if (is_data && (status_in == brb_pkg::ST_DONE)) begin
               ctl.wr    = is_enq;
               ctl.rd    = is_read;
               ctl.count = count_ff[brb_pkg::PASS_COUNT_W-1:0];
               pass_base = xfer_ptr;
            end
         end
         S_WRAP: begin
            ctl.wr    = is_enq;
            ctl.rd    = is_read;
            ctl.off   = off_ff;
            ctl.count = count_ff[brb_pkg::PASS_COUNT_W-1:0];
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   // Pointer advance, wrapped once at the slot count.
   always_comb begin
      wr_sum = SW'(wr_ptr_ff) + SW'(amt_ff);
      rd_sum = SW'(rd_ptr_ff) + SW'(amt_ff);
      if (wr_sum >= SW'(SLOTS)) begin
         wr_sum = wr_sum - SW'(SLOTS);
      end
      if (rd_sum >= SW'(SLOTS)) begin
         rd_sum = rd_sum - SW'(SLOTS);
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_row_in   = clr_row_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         S_CLEAR: begin
            clr_row_in = clr_row_ff + ROW_W'(1);
            if (clr_row_ff == ROW_W'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = wrap_in ? S_WRAP : S_COMMIT;
         end
         S_WRAP: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (op_ff == brb_pkg::OP_CLEAR) begin
               rd_ptr_in = '0;
               wr_ptr_in = '0;
            end else begin
               if (adv_wr_ff) begin
                  wr_ptr_in = PTR_W'(wr_sum);
               end
               if (adv_rd_ff) begin
                  rd_ptr_in = PTR_W'(rd_sum);
               end
            end
            state_in = S_REPORT;
         end
         S_REPORT: begin
            if (rsp_free_slot) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_row_ff   <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         adv_rd_ff    <= 1'b0;
         adv_wr_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_EXEC) begin
            adv_rd_ff <= adv_rd_in;
            adv_wr_ff <= adv_wr_in;
         end
      end
   end

   // Transaction payload and step results.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_chan.operation;
         count_ff <= req_chan.byte_count;
         data_ff  <= req_chan.data_bytes;
      end
      if (state_ff == S_EXEC) begin
         status_ff <= status_in;
         done_ff   <= done_in;
         amt_ff    <= amt_in;
         off_ff    <= off_in;
      end
      if ((state_ff == S_REPORT) && rsp_free_slot) begin
         rsp_status_ff <= status_ff;
         rsp_done_ff   <= done_ff;
         rsp_bytes_ff  <= merged_bytes;
         rsp_used_ff   <= used_now[brb_pkg::SIZE_W-1:0];
         rsp_free_ff   <= free_now[brb_pkg::SIZE_W-1:0];
         rsp_denq_ff   <= denq_now[brb_pkg::SIZE_W-1:0];
         rsp_ddeq_ff   <= ddeq_now[brb_pkg::SIZE_W-1:0];
      end
   end

   // Byte banks: slot s lives in bank s mod BANKS, row s / BANKS.
   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      brb_lane #(
         .CAPACITY (CAPACITY),
         .LANES    (LANES),
         .BANK     (b)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .base       (pass_base),
         .clr_row    (clr_row_ff),
         .data_bytes (data_ff),
         .sel        (sel[b]),
         .rdata      (bank_data[b])
      );
   end

   // The accumulator is cleared as a transaction is taken and collects each
   // pass in the cycle after its bank read.
   brb_merge #(
      .BANKS (BANKS)
   ) u_merge (
      .clock      (clock),
      .start      (req_fire),
      .sel        (sel),
      .rdata      (bank_data),
      .read_bytes (merged_bytes)
   );

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.status              = rsp_status_ff;
   assign rsp_chan.done_count          = rsp_done_ff;
   assign rsp_chan.read_bytes          = rsp_bytes_ff;
   assign rsp_chan.used_size           = rsp_used_ff;
   assign rsp_chan.free_size           = rsp_free_ff;
   assign rsp_chan.direct_enqueue_size = rsp_denq_ff;
   assign rsp_chan.direct_dequeue_size = rsp_ddeq_ff;

endmodule

// ----- sv/brb_ram.sv -----
// Generic single-port RAM with registered read data.
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/brb_lane.sv -----
// One byte bank: maps a pass onto this bank's row and byte lane.
module brb_lane #(
   parameter int CAPACITY = 1023,
   parameter int LANES    = 8,
   parameter int BANK     = 0
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  brb_pkg::pass_ctl_type                         ctl,
   input  logic [$clog2(CAPACITY+1)-1:0]                 base,
   input  logic [$clog2(((CAPACITY+1) + (1 << $clog2(LANES)) - 1)
                        / (1 << $clog2(LANES)))-1:0]     clr_row,
   input  logic [brb_pkg::DATA_W-1:0]                    data_bytes,
   output brb_pkg::lane_sel_type                         sel,
   output logic [7:0]                                    rdata
);

   localparam int SLOTS = CAPACITY + 1;
   localparam int PTR_W = $clog2(SLOTS);
   localparam int BL    = $clog2(LANES);
   localparam int BANKS = 1 << BL;
   localparam int ROWS  = (SLOTS + BANKS - 1) / BANKS;
   localparam int ROW_W = $clog2(ROWS);

   logic [brb_pkg::LANE_W-1:0]       bank_gap;
   logic [PTR_W:0]                   addr;
   logic [brb_pkg::PASS_COUNT_W-1:0] lane;
   logic                             hit;
   logic                             we;
   logic [ROW_W-1:0]                 row;
   logic [7:0]                       wbyte;
   brb_pkg::lane_sel_type            sel_ff;
   brb_pkg::lane_sel_type            sel_in;

   // Distance from the pass base to the first address that falls in this bank.
   always_comb begin
      bank_gap = brb_pkg::LANE_W'((BANK + BANKS - (int'(base) % BANKS)) % BANKS);
      addr  = {1'b0, base} + (PTR_W+1)'(bank_gap);
      lane  = {1'b0, ctl.off} + {1'b0, bank_gap};
      hit   = (lane < ctl.count) && (addr < (PTR_W+1)'(SLOTS));
      row   = ROW_W'(addr >> BL);
      wbyte = data_bytes[{lane[brb_pkg::LANE_W-1:0], 3'b000} +: 8];
      we    = ctl.clear || (ctl.wr && hit);
      sel_in.en   = ctl.rd && hit && !ctl.clear;
      sel_in.lane = lane[brb_pkg::LANE_W-1:0];
   end

   brb_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .addr  (ctl.clear ? clr_row : row),
      .wdata (ctl.clear ? 8'h00 : wbyte),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   assign sel = sel_ff;

endmodule

// ----- sv/brb_merge.sv -----
// Gathers the bank read data into byte order of the transaction.
module brb_merge #(
   parameter int BANKS = 8
) (
   input  logic                       clock,
   input  logic                       start,
   input  brb_pkg::lane_sel_type      sel [BANKS],
   input  logic [7:0]                 rdata [BANKS],
   output logic [brb_pkg::DATA_W-1:0] read_bytes
);

   logic [7:0] acc_ff [brb_pkg::DATA_BYTES];
   logic [7:0] acc_in [brb_pkg::DATA_BYTES];

   always_comb begin
      for (int i = 0; i < brb_pkg::DATA_BYTES; i++) begin
         acc_in[i] = start ? 8'h00 : acc_ff[i];
      end
      for (int b = 0; b < BANKS; b++) begin
         if (sel[b].en && !start) begin
            acc_in[sel[b].lane] = rdata[b];
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   always_comb begin
      for (int i = 0; i < brb_pkg::DATA_BYTES; i++) begin
         read_bytes[8*i +: 8] = acc_ff[i];
      end
   end

endmodule
